>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on i_clk, held off while i_rst_n is low
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

>>> design/cct_pkg.sv
// constants and types of the console column tracker
package cct_pkg;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;
    localparam int TAB_W  = 6;

    localparam logic [BYTE_W-1:0] LINE_WIDTH_RST = 8'd80;
    localparam logic              AUTO_WRAP_RST  = 1'b1;
    localparam logic [TAB_W-1:0]  TAB_WIDTH_RST  = 6'd8;
    localparam logic [TAB_W-1:0]  TAB_MIN        = 6'd8;
    localparam logic [TAB_W-1:0]  TAB_MAX        = 6'd32;
    localparam logic [BYTE_W-1:0] MIN_WRAP_WIDTH = 8'd20;
    localparam logic [BYTE_W-1:0] COL_MAX        = 8'hFF;

    localparam logic [BYTE_W-1:0] CH_BELL  = 8'h07;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT      = 2'd0,
        CMD_RESERVE  = 2'd1,
        CMD_ENDLINE  = 2'd2,
        CMD_CLRLINES = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_WIDTH = 2'd0,
        REG_AUTO_WRAP  = 2'd1,
        REG_TAB_WIDTH  = 2'd2
    } t_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              wrapped;
        logic [BYTE_W-1:0] column;
        logic [BYTE_W-1:0] line_count;
        logic              last;
    } t_out_item;

endpackage

>>> design/cct_if.sv
// handshake interfaces of the console column tracker

interface cct_in_if import cct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] char_in;
    logic [BYTE_W-1:0] increment;

    modport source (output valid, command, char_in, increment, input ready);
    modport sink   (input valid, command, char_in, increment, output ready);
endinterface

interface cct_out_if import cct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              wrapped;
    logic [BYTE_W-1:0] column;
    logic [BYTE_W-1:0] line_count;
    logic              last;

    modport source (output valid, out_byte, out_valid, wrapped, column, line_count, last,
                    input ready);
    modport sink   (input valid, out_byte, out_valid, wrapped, column, line_count, last,
                    output ready);
endinterface

interface cct_cfg_if import cct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/console_column_tracker.sv
// console column tracker: top level with tab-stop sequencer and output register
//
// Shapes a stream of console commands into console bytes and keeps the output
// column and line count. Spaces and tabs only move the column; before the next
// printing character they go out as tabs to the tab stops and then spaces.
// Each input beat produces one or more result beats, the final one flagged by
// last; an input that sends nothing gives one beat with out_valid low. Every
// beat of an item already shows the column and line count after the item.
// Timing: the input is taken in idle, then a tab stop search runs where one is
// needed (a put of a tab, or a printing character with held whitespace). That
// search is one shared 9-bit add and compare stepping by the tab width, one
// stop per cycle. The settle state then sets the new column, wrap and line
// count, and after that one result beat leaves per cycle while the sink takes
// them. Ready comes back in the cycle after the final beat is loaded; a
// printing character after a long run of whitespace gives at most 40 beats.
// The configuration port is always ready and writes are expected only while
// the block is idle; index 3 is ignored.

module console_column_tracker import cct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cct_in_if.sink      i_in,
    cct_out_if.source   o_out,
    cct_cfg_if.sink     i_cfg
);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_STOP   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_FLUSH  = 7'b0001000,
        S_MAIN   = 7'b0010000,
        S_TAIL   = 7'b0100000,
        S_EMPTY  = 7'b1000000
    } t_state;

    // outcome of the settle cycle
    typedef struct packed {
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] pcol;
        logic              wmr;
        logic [BYTE_W-1:0] lines;
        logic              flush;
        logic              main;
        logic [BYTE_W-1:0] main_byte;
        logic              nl_after;
        logic              wr;
    } t_step;

    t_state r_state;

    // configuration registers
    logic [BYTE_W-1:0] r_line_width;
    logic              r_auto_wrap;
    logic [TAB_W-1:0]  r_tab_width;

    // tracked console state
    logic [BYTE_W-1:0] r_col;
    logic [BYTE_W-1:0] r_pcol;
    logic              r_wmr;
    logic [BYTE_W-1:0] r_lines;

    // per-item working registers
    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_ch;
    logic [BYTE_W-1:0] r_inc;
    logic [BYTE_W-1:0] r_walk;      // column reached by output sent so far
    logic [BYTE_W-1:0] r_end;       // column before the item
    logic [BYTE_W:0]   r_stop;      // next tab stop, may pass 255
    logic [BYTE_W-1:0] r_byte;
    logic              r_nl_after;
    logic              r_wr;

    // output register
    logic              r_ov;
    t_out_item         r_out;

    logic              w_in_acc;
    logic              w_load;
    logic              w_need_stop;
    logic              w_new_print;
    logic [TAB_W-1:0]  w_tab;
    logic [BYTE_W-1:0] w_stop_base;
    logic              w_stop_done;
    logic [BYTE_W:0]   w_stop_sum;
    logic              w_flush_tab;
    logic [BYTE_W-1:0] w_walk_next;
    logic              w_flush_done;
    logic              w_is_print;
    logic              w_wrap_ok;
    logic [BYTE_W-1:0] w_lines_inc;
    logic [BYTE_W:0]   w_col_p1;
    logic [BYTE_W:0]   w_col_inc;
    logic [BYTE_W:0]   w_blank_tgt;
    logic [BYTE_W:0]   w_width9;
    t_step             w_d;
    logic              w_beat_en;
    t_out_item         w_beat;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    // output register frees up when empty or when its beat is taken
    assign w_load      = !r_ov || o_out.ready;

    // effective tab width, clamped to 8..32
    assign w_tab = (r_tab_width < TAB_MIN) ? TAB_MIN :
                   (r_tab_width > TAB_MAX) ? TAB_MAX : r_tab_width;

    // a tab stop is needed for a tab, or for a printing char with held whitespace
    assign w_new_print = (i_in.char_in > CH_SPACE) && (i_in.char_in <= CH_TILDE);
    assign w_need_stop = (t_cmd'(i_in.command) == CMD_PUT) &&
                         ((i_in.char_in == CH_TAB) || (w_new_print && (r_pcol < r_col)));

    // ---------------------------------------------------------------
    // shared add/compare unit: steps r_stop until it passes the base
    // ---------------------------------------------------------------
    assign w_stop_base = (r_ch == CH_TAB) ? r_end : r_walk;
    assign w_stop_sum  = r_stop + {3'b000, w_tab};
    assign w_stop_done = r_stop > {1'b0, w_stop_base};

    // whitespace flush: a tab when the next stop is still within reach
    assign w_flush_tab  = {1'b0, r_end} >= r_stop;
    assign w_walk_next  = w_flush_tab ? r_stop[BYTE_W-1:0] : r_walk + 8'd1;
    assign w_flush_done = (w_walk_next == r_end);

    // ---------------------------------------------------------------
    // settle cycle: new state and the bytes to send
    // ---------------------------------------------------------------
    assign w_is_print  = (r_ch > CH_SPACE) && (r_ch <= CH_TILDE);
    assign w_wrap_ok   = r_line_width >= MIN_WRAP_WIDTH;
    assign w_lines_inc = (r_lines == COL_MAX) ? r_lines : r_lines + 8'd1;
    assign w_col_p1    = {1'b0, r_col} + 9'd1;
    assign w_col_inc   = {1'b0, r_col} + {1'b0, r_inc};
    assign w_blank_tgt = (r_ch == CH_TAB) ? r_stop : w_col_p1;
    assign w_width9    = {1'b0, r_line_width};

    always_comb begin
        w_d.col       = r_col;
        w_d.pcol      = r_pcol;
        w_d.wmr       = r_wmr;
        w_d.lines     = r_lines;
        w_d.flush     = 1'b0;
        w_d.main      = 1'b0;
        w_d.main_byte = CH_NL;
        w_d.nl_after  = 1'b0;
        w_d.wr        = 1'b0;
        unique case (r_cmd)
            CMD_PUT: begin
                if (w_is_print) begin
                    // held whitespace, the character, then maybe a wrap newline
                    w_d.flush     = r_walk < r_end;
                    w_d.main      = 1'b1;
                    w_d.main_byte = r_ch;
                    w_d.wmr       = 1'b0;
                    if (w_wrap_ok && (w_col_p1 >= w_width9)) begin
                        w_d.nl_after = !r_auto_wrap;
                        w_d.col      = '0;
                        w_d.pcol     = '0;
                        w_d.wmr      = 1'b1;
                        w_d.lines    = w_lines_inc;
                    end else begin
                        w_d.col  = w_col_p1[BYTE_W] ? COL_MAX : w_col_p1[BYTE_W-1:0];
                        w_d.pcol = w_d.col;
                    end
                end else if (r_ch == CH_NL) begin
                    // newline right after a wrap is swallowed
                    if (r_wmr) begin
                        w_d.wmr = 1'b0;
                    end else begin
                        w_d.main  = 1'b1;
                        w_d.col   = '0;
                        w_d.pcol  = '0;
                        w_d.lines = w_lines_inc;
                    end
                end else if ((r_ch == CH_TAB) || (r_ch == CH_SPACE)) begin
                    // whitespace only moves the column; wrapping on it always sends newline
                    if (w_wrap_ok && (w_blank_tgt >= w_width9)) begin
                        w_d.main  = 1'b1;
                        w_d.col   = '0;
                        w_d.pcol  = '0;
                        w_d.wmr   = 1'b1;
                        w_d.lines = w_lines_inc;
                    end else begin
                        w_d.col = w_blank_tgt[BYTE_W] ? COL_MAX : w_blank_tgt[BYTE_W-1:0];
                    end
                end else if (r_ch == CH_BELL) begin
                    w_d.main      = 1'b1;
                    w_d.main_byte = CH_BELL;
                end
            end
            CMD_RESERVE: begin
                if (w_wrap_ok && (w_col_inc >= w_width9)) begin
                    w_d.main  = !r_auto_wrap || (r_pcol != r_col);
                    w_d.col   = '0;
                    w_d.pcol  = '0;
                    w_d.wmr   = 1'b1;
                    w_d.lines = w_lines_inc;
                    w_d.wr    = 1'b1;
                end
            end
            CMD_ENDLINE: begin
                // no minimum width here
                if (w_col_p1 >= w_width9) begin
                    w_d.main  = !r_auto_wrap;
                    w_d.col   = '0;
                    w_d.pcol  = '0;
                    w_d.wmr   = 1'b1;
                    w_d.lines = w_lines_inc;
                end
            end
            CMD_CLRLINES: begin
                w_d.lines = '0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // result beats
    // ---------------------------------------------------------------
    always_comb begin
        w_beat_en         = 1'b0;
        w_beat.out_byte   = '0;
        w_beat.out_valid  = 1'b0;
        w_beat.wrapped    = r_wr;
        w_beat.column     = r_col;
        w_beat.line_count = r_lines;
        w_beat.last       = 1'b1;
        unique case (r_state)
            S_FLUSH: begin
                w_beat_en        = w_load;
                w_beat.out_byte  = w_flush_tab ? CH_TAB : CH_SPACE;
                w_beat.out_valid = 1'b1;
                w_beat.last      = 1'b0;
            end
            S_MAIN: begin
                w_beat_en        = w_load;
                w_beat.out_byte  = r_byte;
                w_beat.out_valid = 1'b1;
                w_beat.last      = !r_nl_after;
            end
            S_TAIL: begin
                w_beat_en        = w_load;
                w_beat.out_byte  = CH_NL;
                w_beat.out_valid = 1'b1;
            end
            S_EMPTY: begin
                w_beat_en = w_load;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer and tracked state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_pcol  <= '0;
            r_wmr   <= 1'b0;
            r_lines <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_need_stop ? S_STOP : S_DECIDE;
                    end
                end
                S_STOP: begin
                    if (w_stop_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_col   <= w_d.col;
                    r_pcol  <= w_d.pcol;
                    r_wmr   <= w_d.wmr;
                    r_lines <= w_d.lines;
                    if (w_d.flush) begin
                        r_state <= S_FLUSH;
                    end else if (w_d.main) begin
                        r_state <= S_MAIN;
                    end else begin
                        r_state <= S_EMPTY;
                    end
                end
                S_FLUSH: begin
                    if (w_load && w_flush_done) begin
                        r_state <= S_MAIN;
                    end
                end
                S_MAIN: begin
                    if (w_load) begin
                        r_state <= r_nl_after ? S_TAIL : S_IDLE;
                    end
                end
                S_TAIL: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMPTY: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc) begin
            r_cmd  <= t_cmd'(i_in.command);
            r_ch   <= i_in.char_in;
            r_inc  <= i_in.increment;
            r_walk <= r_pcol;
            r_end  <= r_col;
            r_stop <= '0;
        end
        if ((r_state == S_STOP) && !w_stop_done) begin
            r_stop <= w_stop_sum;
        end
        if (r_state == S_DECIDE) begin
            r_byte     <= w_d.main_byte;
            r_nl_after <= w_d.nl_after;
            r_wr       <= w_d.wr;
        end
        if ((r_state == S_FLUSH) && w_load) begin
            r_walk <= w_walk_next;
            if (w_flush_tab) begin
                r_stop <= w_stop_sum;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_beat_en) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_beat_en) begin
            r_out <= w_beat;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_out.out_byte;
    assign o_out.out_valid  = r_out.out_valid;
    assign o_out.wrapped    = r_out.wrapped;
    assign o_out.column     = r_out.column;
    assign o_out.line_count = r_out.line_count;
    assign o_out.last       = r_out.last;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_auto_wrap  <= AUTO_WRAP_RST;
            r_tab_width  <= TAB_WIDTH_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_LINE_WIDTH: r_line_width <= i_cfg.data;
                REG_AUTO_WRAP:  r_auto_wrap  <= i_cfg.data[0];
                REG_TAB_WIDTH:  r_tab_width  <= i_cfg.data[TAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> design/cct_checker.sv
// port-level checker of the console column tracker and its bind
`include "assert_macros.svh"

module cct_checker import cct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BYTE_W-1:0] i_out_byte,
    input  logic [BYTE_W-1:0] i_out_column,
    input  logic [BYTE_W-1:0] i_out_line_count,
    input  logic              i_out_last
);

    // a taken item keeps the input closed for at least the next cycle
    `ASSERT_PROP(a_in_busy, (i_in_valid && i_in_ready) |=> !i_in_ready, "input open after accept")

    // stalled result beat holds
    `ASSERT_PROP(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)), "stalled beat changed")

    // beats of one item follow back to back and share column and line count
    `ASSERT_PROP(a_beat_follow, (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid && (i_out_column == $past(i_out_column)) && (i_out_line_count == $past(i_out_line_count))), "item beats broken")

    // no new item while one is still part way out
    `ASSERT_NEVER(a_mid_item, i_out_valid && !i_out_last && i_in_ready, "input open mid item")

endmodule

bind console_column_tracker cct_checker u_cct_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_column     (o_out.column),
    .i_out_line_count (o_out.line_count),
    .i_out_last       (o_out.last)
);

>>> test/testbench.sv
// self-checking testbench of the console column tracker
`timescale 1ns / 100ps

module testbench;
    import cct_pkg::*;

    // settle time before a register write or after a sender pause
    localparam int SETTLE = 8;
    // index with no register behind it
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        P_ITEM,
        P_CFG,
        P_HOLD
    } t_pend_kind;

    typedef struct {
        t_pend_kind        kind;
        t_cmd              cmd;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] inc;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_pend;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cct_in_if  in_bus ();
    cct_out_if out_bus ();
    cct_cfg_if cfg_bus ();

    console_column_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #2 i_clk = ~i_clk;

    // work waiting for the driver, and beats still owed by the block
    t_pend      pending_work [$];
    t_out_item  beats_due [$];
    int         faults = 0;

    // handshake flags raised at the rising edge, consumed at the falling edge
    bit in_took  = 1'b0;
    bit cfg_took = 1'b0;

    // shadow of the register file
    logic [BYTE_W-1:0] c_lw = LINE_WIDTH_RST;
    logic              c_aw = AUTO_WRAP_RST;
    logic [TAB_W-1:0]  c_tw = TAB_WIDTH_RST;

    // shadow of the column state
    int                col_now   = 0;
    int                col_sent  = 0;
    bit                wrap_nl   = 1'b0;
    int                lines_now = 0;
    logic [BYTE_W-1:0] bytes_out [$];

    // register values that hit the edges of each field
    logic [BYTE_W-1:0] lw_pool [11] = '{8'd0, 8'd1, 8'd19, 8'd20, 8'd21, 8'd40,
                                        8'd80, 8'd128, 8'd254, 8'd255, 8'd33};
    logic [BYTE_W-1:0] tw_pool [10] = '{8'd0, 8'd7, 8'd8, 8'd9, 8'd16, 8'd31,
                                        8'd32, 8'd33, 8'd63, 8'hC8};

    // pacing state of both sides
    int send_gap    = 0;
    int send_streak = 0;
    int sink_hold   = 0;
    int sink_streak = 0;
    int idle_run    = 0;

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= 10) $display("%s", msg);
    endtask

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int gap_len(inout int streak);
        int r;
        if (streak > 0) begin
            streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            streak = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // next tab stop strictly after pos, tab width clamped to 8..32
    function automatic int next_stop(input int pos);
        int t;
        t = (c_tw < TAB_MIN) ? int'(TAB_MIN) : (c_tw > TAB_MAX) ? int'(TAB_MAX) : int'(c_tw);
        return ((pos + t) / t) * t;
    endfunction

    task automatic count_line();
        if (lines_now < 255) lines_now++;
    endtask

    task automatic new_line();
        col_now  = 0;
        col_sent = 0;
        wrap_nl  = 1'b1;
        count_line();
    endtask

    // move the column, wrapping when the width allows it
    task automatic advance_to(input int target, input bit blank);
        if (int'(c_lw) >= int'(MIN_WRAP_WIDTH) && target >= int'(c_lw)) begin
            if (!c_aw || blank) bytes_out.push_back(CH_NL);
            new_line();
        end else begin
            col_now = (target > int'(COL_MAX)) ? int'(COL_MAX) : target;
        end
    endtask

    // works out the console bytes of one command and queues the beats owed
    task automatic shape_console(input t_cmd cmd, input logic [BYTE_W-1:0] ch,
                                 input logic [BYTE_W-1:0] inc);
        int        p;
        int        nt;
        int        n;
        bit        wr;
        t_out_item beat;
        bytes_out.delete();
        wr = 1'b0;
        case (cmd)
            CMD_PUT: begin
                if (ch > CH_SPACE && ch <= CH_TILDE) begin
                    // held whitespace goes out as tabs to the stops, then spaces
                    p = col_sent;
                    while (p < col_now) begin
                        nt = next_stop(p);
                        if (nt <= col_now) begin
                            bytes_out.push_back(CH_TAB);
                            p = nt;
                        end else begin
                            bytes_out.push_back(CH_SPACE);
                            p++;
                        end
                    end
                    col_sent = col_now;
                    bytes_out.push_back(ch);
                    wrap_nl = 1'b0;
                    advance_to(col_now + 1, 1'b0);
                    col_sent = col_now;
                end else if (ch == CH_NL) begin
                    // a newline straight after a wrap is swallowed
                    if (wrap_nl) begin
                        wrap_nl = 1'b0;
                    end else begin
                        bytes_out.push_back(CH_NL);
                        col_now  = 0;
                        col_sent = 0;
                        count_line();
                    end
                end else if (ch == CH_TAB) begin
                    advance_to(next_stop(col_now), 1'b1);
                end else if (ch == CH_SPACE) begin
                    advance_to(col_now + 1, 1'b1);
                end else if (ch == CH_BELL) begin
                    bytes_out.push_back(ch);
                end
            end
            CMD_RESERVE: begin
                if (int'(c_lw) >= int'(MIN_WRAP_WIDTH) && col_now + int'(inc) >= int'(c_lw)) begin
                    if (!c_aw || col_sent != col_now) bytes_out.push_back(CH_NL);
                    new_line();
                    wr = 1'b1;
                end
            end
            CMD_ENDLINE: begin
                // no minimum width here, so width 0 always wraps
                if (col_now + 1 >= int'(c_lw)) begin
                    if (!c_aw) bytes_out.push_back(CH_NL);
                    new_line();
                end
            end
            CMD_CLRLINES: begin
                lines_now = 0;
            end
        endcase
        n = bytes_out.size();
        for (int k = 0; k < ((n == 0) ? 1 : n); k++) begin
            beat.out_byte   = (n == 0) ? '0 : bytes_out[k];
            beat.out_valid  = (n != 0);
            beat.wrapped    = wr;
            beat.column     = 8'(col_now);
            beat.line_count = 8'(lines_now);
            beat.last       = (n == 0) || (k == n - 1);
            beats_due.push_back(beat);
        end
    endtask

    task automatic queue_item(input t_cmd cmd, input logic [BYTE_W-1:0] ch,
                              input logic [BYTE_W-1:0] inc);
        t_pend e;
        e.kind = P_ITEM;
        e.cmd  = cmd;
        e.ch   = ch;
        e.inc  = inc;
        e.idx  = '0;
        e.data = '0;
        pending_work.push_back(e);
    endtask

    // put with a random don't-care increment
    task automatic queue_put(input logic [BYTE_W-1:0] ch);
        queue_item(CMD_PUT, ch, 8'($urandom));
    endtask

    task automatic queue_cfg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        t_pend e;
        e.kind = P_CFG;
        e.cmd  = CMD_PUT;
        e.ch   = '0;
        e.inc  = '0;
        e.idx  = idx;
        e.data = data;
        pending_work.push_back(e);
    endtask

    task automatic queue_hold();
        t_pend e;
        e.kind = P_HOLD;
        e.cmd  = CMD_PUT;
        e.ch   = '0;
        e.inc  = '0;
        e.idx  = '0;
        e.data = '0;
        pending_work.push_back(e);
    endtask

    // known values on every input from time zero
    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.command    = '0;
        in_bus.char_in    = '0;
        in_bus.increment  = '0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
    end

    // input and register driver, fed from the pending queue
    always @(negedge i_clk) begin : drive_in
        logic  drive_v;
        logic  cfg_v;
        t_pend e;
        if (i_rst_n) begin
            drive_v = in_bus.valid;
            cfg_v   = cfg_bus.valid;
            if (in_took) begin
                drive_v = 1'b0;
                in_took = 1'b0;
            end
            if (cfg_took) begin
                cfg_v    = 1'b0;
                cfg_took = 1'b0;
            end
            // count cycles with nothing in flight and nothing owed
            if (!drive_v && !cfg_v && beats_due.size() == 0) idle_run++;
            else idle_run = 0;
            if (!drive_v && !cfg_v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_work.size() != 0) begin
                    case (pending_work[0].kind)
                        P_ITEM: begin
                            e = pending_work.pop_front();
                            in_bus.command   <= e.cmd;
                            in_bus.char_in   <= e.ch;
                            in_bus.increment <= e.inc;
                            drive_v  = 1'b1;
                            send_gap = gap_len(send_streak);
                        end
                        P_CFG: begin
                            // registers change only once the block has gone quiet
                            if (idle_run >= SETTLE) begin
                                e = pending_work.pop_front();
                                cfg_bus.index <= e.idx;
                                cfg_bus.data  <= e.data;
                                cfg_v    = 1'b1;
                                idle_run = 0;
                            end
                        end
                        P_HOLD: begin
                            if (idle_run >= SETTLE) void'(pending_work.pop_front());
                        end
                        default: void'(pending_work.pop_front());
                    endcase
                end
            end
            in_bus.valid  <= drive_v;
            cfg_bus.valid <= cfg_v;
        end
    end

    // result sink with random back-pressure
    always @(negedge i_clk) begin : drive_sink
        if (i_rst_n) begin
            if (sink_hold > 0) begin
                out_bus.ready <= 1'b0;
                sink_hold--;
            end else begin
                out_bus.ready <= 1'b1;
                sink_hold = gap_len(sink_streak);
            end
        end
    end

    // monitor: checks result beats, then predicts from accepted beats
    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item want;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.out_byte   = out_bus.out_byte;
                got.out_valid  = out_bus.out_valid;
                got.wrapped    = out_bus.wrapped;
                got.column     = out_bus.column;
                got.line_count = out_bus.line_count;
                got.last       = out_bus.last;
                if (beats_due.size() == 0) begin
                    note_fault($sformatf("unexpected beat: byte %h vld %b col %0d lines %0d",
                                         got.out_byte, got.out_valid, got.column,
                                         got.line_count));
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want)
                        note_fault($sformatf({"mismatch (want/got): byte %h/%h vld %b/%b ",
                                              "wrap %b/%b col %0d/%0d lines %0d/%0d last %b/%b"},
                                             want.out_byte, got.out_byte,
                                             want.out_valid, got.out_valid,
                                             want.wrapped, got.wrapped,
                                             want.column, got.column,
                                             want.line_count, got.line_count,
                                             want.last, got.last));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                shape_console(t_cmd'(in_bus.command), in_bus.char_in, in_bus.increment);
                in_took = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    REG_LINE_WIDTH: c_lw = cfg_bus.data;
                    REG_AUTO_WRAP:  c_aw = cfg_bus.data[0];
                    REG_TAB_WIDTH:  c_tw = cfg_bus.data[TAB_W-1:0];
                    default: ;
                endcase
                cfg_took = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int r;
        int runs;
        // directed part, reset settings first
        queue_put("A");
        queue_put(CH_SPACE);
        queue_put(CH_SPACE);
        queue_put(CH_TAB);
        queue_put("B");              // held space and tab flushed as one tab
        queue_put(8'h21);            // lowest printing character
        queue_put(CH_TILDE);         // highest printing character
        queue_put(CH_BELL);
        queue_put(8'h01);            // ignored control byte
        queue_put(8'h7F);
        queue_put(8'h80);
        queue_put(8'hFF);
        queue_put(CH_NL);
        queue_item(CMD_RESERVE, 8'($urandom), 8'd255);  // forced wrap, nothing held
        queue_put(CH_NL);            // swallowed after the wrap
        queue_put(CH_SPACE);
        queue_item(CMD_RESERVE, 8'($urandom), 8'd200);  // wrap with whitespace held
        queue_item(CMD_RESERVE, 8'($urandom), 8'd0);
        queue_item(CMD_ENDLINE, 8'($urandom), 8'($urandom));
        queue_item(CMD_CLRLINES, 8'($urandom), 8'($urandom));
        // width zero: end line always wraps, characters never do
        queue_cfg(REG_LINE_WIDTH, 8'd0);
        queue_cfg(REG_AUTO_WRAP, 8'hFE);
        queue_put("x");
        queue_item(CMD_ENDLINE, 8'($urandom), 8'($urandom));
        // no wrapping, wide tabs: column saturates, long flush
        queue_cfg(REG_LINE_WIDTH, 8'd19);
        queue_cfg(REG_TAB_WIDTH, 8'd63);
        for (int k = 0; k < 9; k++) queue_put(CH_TAB);
        queue_put("Z");
        queue_put("Y");
        // tab width below range, narrowest wrapping width
        queue_cfg(REG_TAB_WIDTH, 8'd0);
        queue_cfg(REG_LINE_WIDTH, 8'd20);
        queue_cfg(REG_SPARE, 8'($urandom));
        for (int k = 0; k < 3; k++) queue_put(CH_TAB);
        queue_put("q");
        queue_hold();

        // random part: text-like streams under several settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                queue_cfg(REG_LINE_WIDTH, 8'd255);
                queue_cfg(REG_AUTO_WRAP, 8'd0);
                queue_cfg(REG_TAB_WIDTH, 8'd32);
            end else if (ph == 1) begin
                queue_cfg(REG_LINE_WIDTH, 8'd20);
                queue_cfg(REG_AUTO_WRAP, 8'd1);
                queue_cfg(REG_TAB_WIDTH, 8'd8);
            end else begin
                queue_cfg(REG_LINE_WIDTH, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                          : lw_pool[$urandom_range(0, 10)]);
                queue_cfg(REG_AUTO_WRAP, 8'($urandom));
                queue_cfg(REG_TAB_WIDTH, tw_pool[$urandom_range(0, 9)]);
            end
            for (int k = 0; k < 25; k++) begin
                // sender waits for the block to drain now and then
                if (k == 12 && ph % 2 == 0) queue_hold();
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    queue_put(8'($urandom_range(33, 126)));
                end else if (r < 60) begin
                    // runs of blanks to push the column out
                    runs = $urandom_range(1, 6);
                    for (int j = 0; j < runs; j++) queue_put(CH_SPACE);
                end else if (r < 68) begin
                    queue_put(CH_TAB);
                end else if (r < 74) begin
                    queue_put(CH_NL);
                end else if (r < 77) begin
                    queue_put(CH_BELL);
                end else if (r < 81) begin
                    queue_put(8'($urandom));
                end else if (r < 88) begin
                    queue_item(CMD_RESERVE, 8'($urandom),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 12)));
                end else if (r < 94) begin
                    queue_item(CMD_ENDLINE, 8'($urandom), 8'($urandom));
                end else if (r < 96) begin
                    queue_item(CMD_CLRLINES, 8'($urandom), 8'($urandom));
                end else begin
                    queue_item(t_cmd'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                end
            end
        end

        // line flood: width zero makes every end line count
        queue_cfg(REG_LINE_WIDTH, 8'd0);
        queue_cfg(REG_AUTO_WRAP, 8'($urandom));
        for (int k = 0; k < 60; k++) begin
            r = $urandom_range(0, 15);
            if (r == 0) queue_put(8'($urandom_range(33, 126)));
            else if (r < 3) queue_put(CH_NL);
            else queue_item(CMD_ENDLINE, 8'($urandom), 8'($urandom));
        end
        queue_item(CMD_CLRLINES, 8'($urandom), 8'($urandom));
        queue_item(CMD_ENDLINE, 8'($urandom), 8'($urandom));

        // single reset, released on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_work.size() != 0 || in_bus.valid || cfg_bus.valid) @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        // room for any stray beat after the last one owed
        repeat (100) @(posedge i_clk);
        if (beats_due.size() != 0)
            note_fault($sformatf("%0d beats never arrived", beats_due.size()));

        if (faults == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #25_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
